@@ hdl/msgd_pkg.sv @@
package msgd_pkg;

  // Token kinds as they appear on the result channel.
  localparam logic [3:0] KIND_NIL     = 4'd0;
  localparam logic [3:0] KIND_BOOL    = 4'd1;
  localparam logic [3:0] KIND_UINT    = 4'd2;
  localparam logic [3:0] KIND_SINT    = 4'd3;
  localparam logic [3:0] KIND_F32     = 4'd4;
  localparam logic [3:0] KIND_F64     = 4'd5;
  localparam logic [3:0] KIND_STRHDR  = 4'd6;
  localparam logic [3:0] KIND_STRBYTE = 4'd7;
  localparam logic [3:0] KIND_ARR     = 4'd8;
  localparam logic [3:0] KIND_MAP     = 4'd9;
  localparam logic [3:0] KIND_UNSUP   = 4'd10;
  localparam logic [3:0] KIND_TRUNC   = 4'd11;

  // Default depth of the queue between classifier and executor.
  localparam int QUEUE_DEPTH = 4;

  // What a byte would mean if it arrived as a type byte.
  typedef enum logic [1:0] {
    OP_EMIT,    // complete token in the type byte itself
    OP_FIXSTR,  // fixstr: header token, then payload bytes
    OP_HDR      // header with length, count or value bytes to follow
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] kind;
    logic [7:0] imm_val;
    logic [3:0] nbytes;
  } cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
    cls_t       cls;
  } item_t;

endpackage

@@ hdl/msgd_in_if.sv @@
interface msgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

@@ hdl/msgd_out_if.sv @@
interface msgd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic        payload_last;

  modport source (output valid, output token_kind, output token_value,
                  output payload_last, input ready);
  modport sink (input valid, input token_kind, input token_value,
                input payload_last, output ready);
endinterface

@@ hdl/msgd_front.sv @@
module msgd_front
  import msgd_pkg::*;
(
  msgd_in_if.sink in_chan,
  input  logic    full,
  output logic    push,
  output item_t   push_item
);

  localparam logic [7:0] TB_NIL     = 8'hC0;
  localparam logic [7:0] TB_FALSE   = 8'hC2;
  localparam logic [7:0] TB_TRUE    = 8'hC3;
  localparam logic [7:0] TB_F32     = 8'hCA;
  localparam logic [7:0] TB_F64     = 8'hCB;
  localparam logic [7:0] TB_STR8    = 8'hD9;
  localparam logic [7:0] TB_STR16   = 8'hDA;
  localparam logic [7:0] TB_STR32   = 8'hDB;
  localparam logic [7:0] TB_ARR16   = 8'hDC;
  localparam logic [7:0] TB_ARR32   = 8'hDD;
  localparam logic [7:0] TB_MAP16   = 8'hDE;
  localparam logic [7:0] TB_MAP32   = 8'hDF;
  localparam logic [7:0] TB_NEG_FIX = 8'hE0;

  logic [7:0] b;
  cls_t       cls;

  assign b = in_chan.data_byte;

  // Context-free decode; the executor decides whether the byte is a type byte.
  always_comb begin
    cls = '{op: OP_EMIT, kind: KIND_UNSUP, imm_val: b, nbytes: 4'd0};
    priority if (!b[7]) begin
      cls.kind = KIND_UINT;
    end else if (b >= TB_NEG_FIX) begin
      cls.kind = KIND_SINT;
    end else if (b[7:5] == 3'b101) begin
      cls.op      = OP_FIXSTR;
      cls.kind    = KIND_STRHDR;
      cls.imm_val = {3'b000, b[4:0]};
    end else if (b[7:4] == 4'b1000) begin
      cls.kind    = KIND_MAP;
      cls.imm_val = {4'b0000, b[3:0]};
    end else if (b[7:4] == 4'b1001) begin
      cls.kind    = KIND_ARR;
      cls.imm_val = {4'b0000, b[3:0]};
    end else if (b == TB_NIL) begin
      cls.kind    = KIND_NIL;
      cls.imm_val = 8'd0;
    end else if (b == TB_FALSE || b == TB_TRUE) begin
      cls.kind    = KIND_BOOL;
      cls.imm_val = {7'd0, b[0]};
    end else if (b == TB_F32) begin
      cls = '{op: OP_HDR, kind: KIND_F32, imm_val: b, nbytes: 4'd4};
    end else if (b == TB_F64) begin
      cls = '{op: OP_HDR, kind: KIND_F64, imm_val: b, nbytes: 4'd8};
    end else if (b[7:2] == 6'b110011) begin
      cls = '{op: OP_HDR, kind: KIND_UINT, imm_val: b, nbytes: 4'd1 << b[1:0]};
    end else if (b[7:2] == 6'b110100) begin
      cls = '{op: OP_HDR, kind: KIND_SINT, imm_val: b, nbytes: 4'd1 << b[1:0]};
    end else if (b == TB_STR8 || b == TB_STR16 || b == TB_STR32) begin
      cls = '{op: OP_HDR, kind: KIND_STRHDR, imm_val: b,
              nbytes: 4'd1 << (b[1:0] - 2'd1)};
    end else if (b == TB_ARR16) begin
      cls = '{op: OP_HDR, kind: KIND_ARR, imm_val: b, nbytes: 4'd2};
    end else if (b == TB_ARR32) begin
      cls = '{op: OP_HDR, kind: KIND_ARR, imm_val: b, nbytes: 4'd4};
    end else if (b == TB_MAP16) begin
      cls = '{op: OP_HDR, kind: KIND_MAP, imm_val: b, nbytes: 4'd2};
    end else if (b == TB_MAP32) begin
      cls = '{op: OP_HDR, kind: KIND_MAP, imm_val: b, nbytes: 4'd4};
    end else begin
      cls.kind = KIND_UNSUP;
    end
  end

  assign in_chan.ready = !full;
  assign push          = in_chan.valid && !full;
  assign push_item     = '{data_byte: b, end_of_buffer: in_chan.end_of_buffer, cls: cls};

endmodule

@@ hdl/msgd_fifo.sv @@
module msgd_fifo
  import msgd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not follow a lone push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("queue count did not follow a lone pop");
`endif

endmodule

@@ hdl/msgd_back.sv @@
module msgd_back
  import msgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  item_t       pop_item,
  output logic        pop,
  msgd_out_if.source  out_chan
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_PAY,
    PH_REST
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pend_kind_r, pend_kind_nxt;
  logic [3:0]  hdr_left_r, hdr_left_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_kind_r, out_kind_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_last_r, out_last_nxt;

  logic [7:0]  b;
  logic [63:0] acc_base;
  logic [63:0] acc_shift;
  logic [3:0]  hdr_dec;
  logic        emit;
  logic [3:0]  e_kind;
  logic [63:0] e_val;
  logic        e_last;

  assign b   = pop_item.data_byte;
  assign pop = !empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    acc_base = acc_r;
    if (phase_r == PH_FIRST) begin
      acc_base = (pend_kind_r == KIND_SINT && b[7]) ? '1 : '0;
    end
    acc_shift = {acc_base[55:0], b};
    hdr_dec   = (hdr_left_r != 4'd0) ? hdr_left_r - 4'd1 : hdr_left_r;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pend_kind_nxt = pend_kind_r;
    hdr_left_nxt  = hdr_left_r;
    acc_nxt       = acc_r;
    pay_left_nxt  = pay_left_r;
    emit          = 1'b0;
    e_kind        = KIND_NIL;
    e_val         = '0;
    e_last        = 1'b0;

    if (pop) begin
      unique case (phase_r)
        PH_IDLE: begin
          unique case (pop_item.cls.op)
            OP_EMIT: begin
              emit   = 1'b1;
              e_kind = pop_item.cls.kind;
              e_val  = (pop_item.cls.kind == KIND_SINT) ?
                       {{56{1'b1}}, pop_item.cls.imm_val} :
                       {56'd0, pop_item.cls.imm_val};
            end
            OP_FIXSTR: begin
              emit   = 1'b1;
              e_kind = KIND_STRHDR;
              e_val  = {56'd0, pop_item.cls.imm_val};
              if (pop_item.cls.imm_val != 8'd0) begin
                pay_left_nxt = {24'd0, pop_item.cls.imm_val};
                phase_nxt    = PH_PAY;
              end
            end
            OP_HDR: begin
              pend_kind_nxt = pop_item.cls.kind;
              hdr_left_nxt  = pop_item.cls.nbytes;
              acc_nxt       = '0;
              phase_nxt     = PH_FIRST;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        PH_PAY: begin
          emit   = 1'b1;
          e_kind = KIND_STRBYTE;
          e_val  = {56'd0, b};
          e_last = (pay_left_r == 32'd1);
          if (pay_left_r != 32'd0) begin
            pay_left_nxt = pay_left_r - 32'd1;
          end
          if (pay_left_nxt == 32'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_FIRST, PH_REST: begin
          acc_nxt      = acc_shift;
          phase_nxt    = PH_REST;
          hdr_left_nxt = hdr_dec;
          if (hdr_dec == 4'd0) begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
            if (pend_kind_r == KIND_STRHDR) begin
              e_kind = KIND_STRHDR;
              e_val  = {32'd0, acc_shift[31:0]};
              if (acc_shift[31:0] != 32'd0) begin
                pay_left_nxt = acc_shift[31:0];
                phase_nxt    = PH_PAY;
              end
            end else begin
              e_kind = pend_kind_r;
              e_val  = acc_shift;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // A buffer that ends inside a token collapses into one truncation token.
      if (pop_item.end_of_buffer && phase_nxt != PH_IDLE) begin
        phase_nxt     = PH_IDLE;
        pend_kind_nxt = KIND_NIL;
        hdr_left_nxt  = 4'd0;
        acc_nxt       = '0;
        pay_left_nxt  = 32'd0;
        emit          = 1'b1;
        e_kind        = KIND_TRUNC;
        e_val         = '0;
        e_last        = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = e_kind;
      out_value_nxt = e_val;
      out_last_nxt  = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_kind_r <= KIND_NIL;
      hdr_left_r  <= 4'd0;
      acc_r       <= '0;
      pay_left_r  <= 32'd0;
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_NIL;
      out_value_r <= '0;
      out_last_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pend_kind_r <= pend_kind_nxt;
      hdr_left_r  <= hdr_left_nxt;
      acc_r       <= acc_nxt;
      pay_left_r  <= pay_left_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = out_kind_r;
  assign out_chan.token_value  = out_value_r;
  assign out_chan.payload_last = out_last_r;

`ifndef SYNTHESIS
  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> pay_left_r != 32'd0)
    else $error("payload phase with no payload bytes left");
  a_hdr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIRST || phase_r == PH_REST) |-> hdr_left_r != 4'd0)
    else $error("header phase with no header bytes left");
  a_last_is_strbyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_kind_r == KIND_STRBYTE)
    else $error("payload_last on a token that is not a string byte");
  a_eob_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_item.end_of_buffer |=> phase_r == PH_IDLE)
    else $error("decoder not idle after end of buffer");
`endif

endmodule

@@ hdl/msgpack_token_decoder.sv @@
// Channel   Direction  Payload                                    Transfer when
// in_chan   input      data_byte[7:0], end_of_buffer              valid && ready
// out_chan  output     token_kind[3:0], token_value[63:0],        valid && ready
//                      payload_last
//
// One byte is taken every cycle while the queue has room; a token leaves after
// its closing byte has passed the queue and then the executor's output register.
// The sustained rate of one byte per cycle is set by the executor, which
// retires one queued byte per cycle whenever its output register is free.
// Reset is synchronous and active low; it empties the queue and returns the
// parser to waiting for a type byte. No clearing pass is needed.
// A stall on out_chan holds the output register; the queue of FIFO_DEPTH
// bytes keeps accepting until it is full, and then in_chan.ready drops.
module msgpack_token_decoder
  import msgd_pkg::*;
#(
  parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  msgd_in_if.sink     in_chan,
  msgd_out_if.source  out_chan
);

  // Front end: handshake on the input side and type-byte classification.
  // Every byte is classified as if it were a type byte; whether it really is
  // one depends on the parse state, which only the executor knows.
  logic  push;
  item_t push_item;
  logic  full;

  // Queue: decouples input transfers from output stalls.
  logic  pop;
  item_t pop_item;
  logic  empty;

  msgd_front u_front (
    .in_chan   (in_chan),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  msgd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  // Executor: runs the header and string-payload state machine, assembles
  // multi-byte fields big-endian, and turns an end of buffer inside a token
  // into a single truncation token.
  msgd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop_item (pop_item),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
